[rtl/core/framed_command_parser_ack_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the framed command parser
// Concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_PARSER_ACK_ASSERT_SVH
`define FRAMED_COMMAND_PARSER_ACK_ASSERT_SVH

`ifndef SYNTHESIS
`define FCP_ASSERT_IMM(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcp assertion failed");
`define FCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcp assertion failed");
`else
`define FCP_ASSERT_IMM(lbl, clk, rst_n, ante, cons)
`define FCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/fcp_pkg.sv]
// ----------------------------------------------------------------------------
// fcp_pkg
// Types and constants shared by the framed command parser modules.
// ----------------------------------------------------------------------------
package fcp_pkg;

    localparam logic [7:0] HDR_IN  = 8'h3E;
    localparam logic [7:0] HDR_OUT = 8'h3C;
    localparam logic [7:0] ACK_OK  = 8'h06;
    localparam logic [7:0] ACK_LEN = 8'h01;

    localparam logic [7:0] CMD_GET_STATUS = 8'd0;
    localparam logic [7:0] CMD_START_SCAN = 8'd1;
    localparam logic [7:0] CMD_STOP_SCAN  = 8'd2;
    localparam logic [7:0] CMD_ATTACH     = 8'd3;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_RESP_EN = 1'b0;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] status_code;
    } t_fcp_in;

    typedef struct packed {
        logic [7:0] resp_byte;
        logic       resp_valid;
        logic       last;
        logic [1:0] scan_request;
    } t_fcp_out;

    // one completed frame awaiting its reply
    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] ack;
        logic [1:0] req;
        logic       resp_en;
    } t_fcp_desc;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_fcp_qstat;

endpackage

[rtl/core/fcp_front.sv]
// ----------------------------------------------------------------------------
// fcp_front
// Frame parser: header hunting, running checksum, reply descriptor push.
// ----------------------------------------------------------------------------
module fcp_front
    import fcp_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = 256,
    parameter int NUM_COMMANDS       = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_fcp_in   i_word,
    input  logic      i_resp_en,
    output logic      o_push,
    output t_fcp_desc o_desc
);

    localparam logic [2:0] ST_HUNT = 3'd0;
    localparam logic [2:0] ST_CMD  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_DATA = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;

    localparam logic [8:0] LEN_LIMIT = 9'(FRAME_BUFFER_BYTES - 3);
    localparam logic [8:0] CMD_LIMIT = 9'(NUM_COMMANDS);

    logic [2:0] r_state, n_state;
    logic [7:0] r_sum,   n_sum;
    logic [7:0] r_cmd,   n_cmd;
    logic [7:0] r_left,  n_left;

    logic [7:0] b;
    logic [7:0] sum_add;
    logic [7:0] left_dec;
    logic [7:0] ack;
    logic [1:0] req;
    logic       known;

    assign b        = i_word.rx_byte;
    assign sum_add  = r_sum + b;
    assign left_dec = r_left - 8'd1;

    always_comb begin
        ack   = ACK_OK;
        req   = REQ_NONE;
        known = 1'b1;
        unique case (r_cmd)
            CMD_GET_STATUS: ack = i_word.status_code;
            CMD_START_SCAN: req = REQ_START;
            CMD_STOP_SCAN:  req = REQ_STOP;
            CMD_ATTACH:     known = 1'b1;
            default:        known = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_cmd   = r_cmd;
        n_left  = r_left;
        o_push  = 1'b0;
        if (i_accept) begin
            unique case (r_state)
                ST_CMD: begin
                    n_sum = sum_add;
                    if ({1'b0, b} < CMD_LIMIT) begin
                        n_cmd   = b;
                        n_state = ST_LEN;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
                ST_LEN: begin
                    n_sum = sum_add;
                    priority if (b == 8'd0) begin
                        n_state = ST_SUM;
                    end else if ({1'b0, b} < LEN_LIMIT) begin
                        n_left  = b;
                        n_state = ST_DATA;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
                ST_DATA: begin
                    n_sum  = sum_add;
                    n_left = left_dec;
                    if (left_dec == 8'd0) begin
                        n_state = ST_SUM;
                    end
                end
                ST_SUM: begin
                    n_sum   = sum_add;
                    n_state = ST_HUNT;
                    o_push  = (sum_add == 8'd0) && known && (i_resp_en || req != REQ_NONE);
                end
                default: begin
                    if (b == HDR_IN) begin
                        n_sum   = b;
                        n_state = ST_CMD;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
            endcase
        end
    end

    assign o_desc.cmd     = r_cmd;
    assign o_desc.ack     = ack;
    assign o_desc.req     = req;
    assign o_desc.resp_en = i_resp_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_sum   <= 8'd0;
            r_cmd   <= 8'd0;
            r_left  <= 8'd0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_cmd   <= n_cmd;
            r_left  <= n_left;
        end
    end

endmodule

[rtl/core/fcp_queue.sv]
// ----------------------------------------------------------------------------
// fcp_queue
// Small FIFO of reply descriptors between parser and reply sequencer.
// ----------------------------------------------------------------------------
module fcp_queue
    import fcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_fcp_desc  i_desc,
    input  logic       i_pop,
    output t_fcp_desc  o_head,
    output t_fcp_qstat o_stat
);

    t_fcp_desc         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    assign o_head = r_mem[r_rptr];

    always_comb begin
        n_wptr  = do_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr  = do_pop  ? r_rptr + QPTR_W'(1) : r_rptr;
        n_count = r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

[rtl/core/fcp_back.sv]
// ----------------------------------------------------------------------------
// fcp_back
// Reply sequencer: expands a descriptor into acknowledgement or request-only words.
// ----------------------------------------------------------------------------
module fcp_back
    import fcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fcp_desc  i_head,
    input  t_fcp_qstat i_qstat,
    output logic       o_pop,
    output logic       o_valid,
    output t_fcp_out   o_word,
    input  logic       i_stall
);

    localparam logic [2:0] IDX_HDR = 3'd0;
    localparam logic [2:0] IDX_CMD = 3'd1;
    localparam logic [2:0] IDX_LEN = 3'd2;
    localparam logic [2:0] IDX_ACK = 3'd3;
    localparam logic [2:0] IDX_CHK = 3'd4;

    logic [2:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    t_fcp_out   r_word, n_word;
    logic       load;
    logic       fin;
    logic [7:0] chk;

    assign load = !i_qstat.empty && (!r_valid || !i_stall);
    assign chk  = 8'h00 - (HDR_OUT + i_head.cmd + ACK_LEN + i_head.ack);

    always_comb begin
        n_word              = r_word;
        n_word.resp_valid   = 1'b1;
        n_word.last         = 1'b0;
        n_word.scan_request = REQ_NONE;
        fin                 = 1'b0;
        if (!i_head.resp_en) begin
            n_word.resp_byte    = 8'h00;
            n_word.resp_valid   = 1'b0;
            n_word.last         = 1'b1;
            n_word.scan_request = i_head.req;
            fin                 = 1'b1;
        end else begin
            unique case (r_idx)
                IDX_HDR: begin
                    n_word.resp_byte    = HDR_OUT;
                    n_word.scan_request = i_head.req;
                end
                IDX_CMD: n_word.resp_byte = i_head.cmd;
                IDX_LEN: n_word.resp_byte = ACK_LEN;
                IDX_ACK: n_word.resp_byte = i_head.ack;
                default: begin
                    n_word.resp_byte = chk;
                    n_word.last      = 1'b1;
                    fin              = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            o_pop   = fin;
            n_idx   = fin ? IDX_HDR : r_idx + 3'd1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= IDX_HDR;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

endmodule

[rtl/core/framed_command_parser_ack.sv]
// Accepts one received byte per clock and parses header-framed commands with
// an additive checksum. A good frame may raise a scan request; with replies
// on it queues a five-word acknowledgement (one request-only word when
// replies are off and a scan is requested). Replies leave one word per clock
// from a registered output unless it is stalled; a reply is queued when its
// checksum byte is taken and leaves after earlier replies. A queue of
// QUEUE_DEPTH pending replies sits between parser and reply sequencer, and
// the input stalls only when that queue is full (a run of short frames
// outpacing the five-word replies, or a stalled output).
// ----------------------------------------------------------------------------
// framed_command_parser_ack
// Top level: APB register, parser front, reply queue, reply sequencer.
// ----------------------------------------------------------------------------
`include "framed_command_parser_ack_assert.svh"

module framed_command_parser_ack
    import fcp_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = 256,
    parameter int NUM_COMMANDS       = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_fcp_in            i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_fcp_out           o_out_data,
    input  logic               i_out_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       r_resp_en;
    logic       cfg_wr;
    logic       in_accept;
    logic       push;
    logic       pop;
    t_fcp_desc  desc;
    t_fcp_desc  head;
    t_fcp_qstat qstat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_RESP_EN);
    assign prdata = (paddr[PADDR_W-1] == REG_RESP_EN) ? {31'd0, r_resp_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_en <= 1'b0;
        end else if (cfg_wr) begin
            r_resp_en <= pwdata[0];
        end
    end

    assign o_in_stall = qstat.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    fcp_front #(
        .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES),
        .NUM_COMMANDS       (NUM_COMMANDS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_word    (i_in_data),
        .i_resp_en (r_resp_en),
        .o_push    (push),
        .o_desc    (desc)
    );

    fcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    fcp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_word  (o_out_data),
        .i_stall (i_out_stall)
    );

    `FCP_ASSERT_IMM(a_req_only_last, i_clk, i_rst_n, o_out_valid && !o_out_data.resp_valid, o_out_data.last)
    `FCP_ASSERT_IMM(a_req_on_hdr, i_clk, i_rst_n, o_out_valid && o_out_data.resp_valid && o_out_data.scan_request != REQ_NONE, o_out_data.resp_byte == HDR_OUT)
    `FCP_ASSERT_IMM(a_q_bound, i_clk, i_rst_n, 1'b1, qstat.count <= QCNT_W'(QUEUE_DEPTH))
    `FCP_ASSERT_NXT(a_reply_burst, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out_data.last, o_out_valid)

endmodule

[bench/tb_framed_command_parser_ack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_command_parser_ack
// Self-checking bench for the framed command parser. Received bytes are sent
// as directed frames, then as random good, corrupt, broken and noise traffic
// with replies switched on and off. A byte-level parser model predicts every
// acknowledgement word, and each word taken from the block is compared with
// it. Both sides idle at random. One long output hold fills the reply queue.
// ----------------------------------------------------------------------------
module tb_framed_command_parser_ack;
    import fcp_pkg::*;

    localparam int FRAME_BUFFER_BYTES = 256;
    localparam int NUM_COMMANDS       = 4;
    localparam int DRAIN_CYCLES       = 16;
    localparam int HOLD_CYCLES        = 120;
    localparam int WATCHDOG_LIMIT     = 3000;
    localparam int PHASE_GOAL         = 30;
    localparam int FILL_FRAMES        = 12;
    localparam logic [PADDR_W-1:0] RESP_EN_ADDR = PADDR_W'(4 * REG_RESP_EN);

    typedef enum logic [2:0] {
        P_HUNT, P_CMD, P_LEN, P_DATA, P_CSUM
    } t_parse;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    t_fcp_in     in_data   = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_fcp_out    o_out_data;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // parser model state
    t_parse      frm_state = P_HUNT;
    logic [7:0]  frm_sum   = '0;
    logic [7:0]  frm_cmd   = '0;
    logic [7:0]  frm_left  = '0;
    logic        resp_en   = 1'b0;

    t_fcp_in     rx_pending [$];
    t_fcp_out    ack_expected [$];

    int unsigned bytes_queued   = 0;
    int unsigned noise_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned good_frames    = 0;
    int unsigned words_checked  = 0;
    int unsigned errors         = 0;
    int unsigned hold_requests  = 0;
    int unsigned hold_served    = 0;
    int unsigned idle_cycles    = 0;
    int unsigned send_gap       = 0;
    logic        send_burst     = 1'b0;
    logic        recv_burst     = 1'b0;
    int unsigned stall_left     = 0;
    int unsigned hold_left      = 0;

    framed_command_parser_ack #(
        .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES),
        .NUM_COMMANDS       (NUM_COMMANDS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void parse_rx_byte(input t_fcp_in item);
        logic [7:0] b;
        logic [7:0] ack;
        logic [7:0] csum;
        logic [1:0] req;
        logic       known;
        logic [7:0] ack_frame [5];
        t_fcp_out   w;
        b = item.rx_byte;
        case (frm_state)
            P_CMD: begin
                frm_sum = frm_sum + b;
                if (b < NUM_COMMANDS) begin
                    frm_cmd   = b;
                    frm_state = P_LEN;
                end else begin
                    frm_state = P_HUNT;
                end
            end
            P_LEN: begin
                frm_sum = frm_sum + b;
                if (b == 8'd0) begin
                    frm_state = P_CSUM;
                end else if (b < FRAME_BUFFER_BYTES - 3) begin
                    frm_left  = b;
                    frm_state = P_DATA;
                end else begin
                    frm_state = P_HUNT;
                end
            end
            P_DATA: begin
                frm_sum  = frm_sum + b;
                frm_left = frm_left - 8'd1;
                if (frm_left == 8'd0) frm_state = P_CSUM;
            end
            P_CSUM: begin
                frm_sum   = frm_sum + b;
                frm_state = P_HUNT;
                if (frm_sum == 8'd0) begin
                    known = 1'b1;
                    req   = REQ_NONE;
                    ack   = ACK_OK;
                    case (frm_cmd)
                        CMD_GET_STATUS: ack = item.status_code;
                        CMD_START_SCAN: req = REQ_START;
                        CMD_STOP_SCAN:  req = REQ_STOP;
                        CMD_ATTACH:     req = REQ_NONE;
                        default:        known = 1'b0;
                    endcase
                    if (known) good_frames++;
                    if (known && !resp_en && req != REQ_NONE) begin
                        w.resp_byte    = 8'h00;
                        w.resp_valid   = 1'b0;
                        w.last         = 1'b1;
                        w.scan_request = req;
                        ack_expected.push_back(w);
                    end else if (known && resp_en) begin
                        ack_frame[0] = HDR_OUT;
                        ack_frame[1] = frm_cmd;
                        ack_frame[2] = ACK_LEN;
                        ack_frame[3] = ack;
                        csum = HDR_OUT + frm_cmd + ACK_LEN + ack;
                        ack_frame[4] = -csum;
                        for (int i = 0; i < 5; i++) begin
                            w.resp_byte    = ack_frame[i];
                            w.resp_valid   = 1'b1;
                            w.last         = (i == 4);
                            w.scan_request = (i == 0) ? req : REQ_NONE;
                            ack_expected.push_back(w);
                        end
                    end
                end
            end
            default: begin
                if (b == HDR_IN) begin
                    frm_sum   = b;
                    frm_state = P_CMD;
                end else begin
                    frm_state = P_HUNT;
                end
            end
        endcase
    endfunction

    // status < 0 draws a random status byte
    function automatic void queue_byte(input logic [7:0] b, input int status);
        t_fcp_in item;
        item.rx_byte     = b;
        item.status_code = (status < 0) ? 8'($urandom_range(0, 255)) : 8'(status);
        rx_pending.push_back(item);
        bytes_queued++;
    endfunction

    // sum_err != 0 corrupts the checksum; fill < 0 gives random data bytes
    function automatic void queue_frame(input logic [7:0] cmd, input logic [7:0] len,
                                        input logic [7:0] sum_err, input int fill,
                                        input int status);
        logic [7:0] sum;
        logic [7:0] d;
        sum = HDR_IN + cmd + len;
        queue_byte(HDR_IN, -1);
        queue_byte(cmd, -1);
        queue_byte(len, -1);
        for (int i = 0; i < len; i++) begin
            d = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            sum = sum + d;
            queue_byte(d, -1);
        end
        queue_byte(8'(-sum + sum_err), status);
    endfunction

    function automatic logic [7:0] pick_len();
        return ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 4))
                                           : 8'($urandom_range(5, 16));
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (bytes_accepted != bytes_queued || ack_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= RESP_EN_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_resp_enable(input logic en);
        logic [31:0] rd;
        apb_access(1'b1, {31'd0, en}, rd);
        resp_en = en;
        apb_access(1'b0, 32'd0, rd);
        if (rd[0] !== en) begin
            errors++;
            if (errors <= 10)
                $display("readback mismatch: expected %0d, got %0d", en, rd[0]);
        end
    endtask

    // byte driver
    always @(posedge i_clk) begin : drive
        logic holding;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            holding = in_valid && o_in_stall;
            if (in_valid && !o_in_stall) begin
                parse_rx_byte(in_data);
                bytes_accepted++;
            end
            if (!holding) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (rx_pending.size() != 0) begin
                    in_data  <= rx_pending.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 4);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // reply monitor and output stall
    always @(posedge i_clk) begin : receive
        t_fcp_out exp_word;
        logic     took;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            took = o_out_valid && !out_stall;
            if (took) begin
                words_checked++;
                if (ack_expected.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: byte %h valid %0d last %0d req %0d",
                                 o_out_data.resp_byte, o_out_data.resp_valid,
                                 o_out_data.last, o_out_data.scan_request);
                end else begin
                    exp_word = ack_expected.pop_front();
                    if (o_out_data.resp_byte !== exp_word.resp_byte ||
                        o_out_data.resp_valid !== exp_word.resp_valid ||
                        o_out_data.last !== exp_word.last ||
                        o_out_data.scan_request !== exp_word.scan_request) begin
                        errors++;
                        if (errors <= 10)
                            $display("word mismatch: exp byte %h valid %0d last %0d req %0d, got byte %h valid %0d last %0d req %0d",
                                     exp_word.resp_byte, exp_word.resp_valid,
                                     exp_word.last, exp_word.scan_request,
                                     o_out_data.resp_byte, o_out_data.resp_valid,
                                     o_out_data.last, o_out_data.scan_request);
                    end
                end
            end
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (took) begin
                if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
                stall_left = recv_burst ? 0 : $urandom_range(0, 4);
                out_stall <= (stall_left != 0);
            end else if (stall_left != 0) begin
                stall_left--;
                out_stall <= (stall_left != 0);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic phase_en [5];
        int unsigned goal;
        int unsigned sel;
        phase_en = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // replies off from reset: only scan requests come out
        queue_byte(8'hFF, -1);
        queue_frame(CMD_START_SCAN, 8'd0, 8'd0, -1, -1);
        queue_frame(CMD_ATTACH, 8'd0, 8'd0, -1, -1);
        wait_idle();

        set_resp_enable(1'b1);
        queue_frame(CMD_GET_STATUS, 8'd0, 8'd0, -1, 8'hFF);
        queue_frame(CMD_STOP_SCAN, 8'd1, 8'd0, HDR_IN, 8'h00);
        queue_byte(HDR_IN, -1);
        queue_byte(8'(NUM_COMMANDS), -1);
        queue_byte(HDR_IN, -1);
        queue_byte(CMD_START_SCAN, -1);
        queue_byte(8'(FRAME_BUFFER_BYTES - 3), -1);
        queue_frame(CMD_ATTACH, 8'd0, 8'd1, -1, -1);
        wait_idle();

        foreach (phase_en[p]) begin
            set_resp_enable(phase_en[p]);
            goal = bytes_queued - noise_queued + PHASE_GOAL;
            if (p == 0) begin
                // short frames against a held output to fill the reply queue
                hold_requests++;
                for (int i = 0; i < FILL_FRAMES; i++)
                    queue_frame(8'($urandom_range(0, 3)), 8'd0, 8'd0, -1, -1);
                goal += 4 * FILL_FRAMES;
            end
            if (p == 4)
                queue_frame(CMD_GET_STATUS, 8'(FRAME_BUFFER_BYTES - 4), 8'd0, -1, -1);
            while (bytes_queued - noise_queued < goal) begin
                sel = $urandom_range(0, 99);
                if (sel < 65) begin
                    queue_frame(8'($urandom_range(0, 3)), pick_len(), 8'd0, -1, -1);
                end else if (sel < 75) begin
                    queue_frame(8'($urandom_range(0, 3)), pick_len(),
                                8'($urandom_range(1, 255)), -1, -1);
                end else if (sel < 85) begin
                    queue_byte(HDR_IN, -1);
                    case ($urandom_range(0, 2))
                        0: queue_byte(8'($urandom_range(NUM_COMMANDS, 255)), -1);
                        1: begin
                            queue_byte(8'($urandom_range(0, 3)), -1);
                            queue_byte(8'($urandom_range(FRAME_BUFFER_BYTES - 3, 255)), -1);
                        end
                        default: queue_byte(8'($urandom_range(0, 3)), -1);
                    endcase
                end else begin
                    queue_byte(8'($urandom_range(0, 255)), -1);
                    noise_queued++;
                end
            end
            wait_idle();
        end

        $display("Sent %0d bytes (%0d noise), %0d good frames, %0d reply words checked",
                 bytes_queued, noise_queued, good_frames, words_checked);
        $display("Replies switched on and off, one long output hold, %0d errors", errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/fcp_pkg.sv
rtl/core/fcp_front.sv
rtl/core/fcp_queue.sv
rtl/core/fcp_back.sv
rtl/core/framed_command_parser_ack.sv
bench/tb_framed_command_parser_ack.sv
